// File: rtl/core/vsrle_pkg.sv
package vsrle_pkg;

  // Fixed field widths of the voxel stream and the run descriptors.
  localparam int WORD_W = 32;
  localparam int ADDR_W = 21;
  localparam int CNT_W  = 15;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 2;

  localparam int MAX_DIM_DEFAULT = 128;

  // Control words of the compressed slice format.
  localparam logic [WORD_W-1:0] CODE_RUN        = 32'd2;
  localparam logic [WORD_W-1:0] CODE_NEXT_SLICE = 32'd6;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_COMPRESSED_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_X          = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_Y          = 2'd2;
  localparam logic [IDX_W-1:0] REG_SIZE_Z          = 2'd3;

  // Decoder phase within the compressed stream.
  typedef enum logic [2:0] {
    PH_WORD  = 3'b001,
    PH_COUNT = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

endpackage

// File: rtl/core/vsrle_in_if.sv
interface vsrle_in_if;
  logic                        valid;
  logic                        ready;
  logic [vsrle_pkg::WORD_W-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

// File: rtl/core/vsrle_out_if.sv
interface vsrle_out_if;
  logic                        valid;
  logic                        ready;
  logic [vsrle_pkg::ADDR_W-1:0] voxel_address;
  logic [vsrle_pkg::CNT_W-1:0]  run_length;
  logic [vsrle_pkg::WORD_W-1:0] voxel_value;
  logic                        overflow;
  logic                        matrix_done;

  modport source (output valid, output voxel_address, output run_length,
                  output voxel_value, output overflow, output matrix_done,
                  input ready);
  modport sink (input valid, input voxel_address, input run_length,
                input voxel_value, input overflow, input matrix_done,
                output ready);
endinterface

// File: rtl/core/voxel_slice_rle_decoder.sv
// A run descriptor is registered and appears on the output in the cycle after the word that causes it.
// Throughput: one data word per cycle; the whole decode step sits between the input
// handshake and the output register. A word is taken in the cycle in which the waiting
// result leaves, so the input stalls only while the receiver holds off.
// Reset (rst, synchronous, active high) selects plain mode with all sizes at 1 and
// returns the decoder to the first voxel of the first slice with no pending run.
module voxel_slice_rle_decoder #(
  parameter int MAX_DIM = vsrle_pkg::MAX_DIM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vsrle_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vsrle_pkg::CFG_W-1:0]   cfg_data,
  vsrle_in_if.sink                      words,
  vsrle_out_if.source                   runs
);

  // The configuration data is 8 bits wide, so a dimension never exceeds 255 even when
  // MAX_DIM is larger. Every width below follows from the effective cap.
  localparam int DIM_CAP = (MAX_DIM > 255) ? 255 : MAX_DIM;
  localparam int DIM_W   = $clog2(DIM_CAP + 1);
  localparam int SLICE_W = 2 * DIM_W;
  localparam int RW      = (SLICE_W > vsrle_pkg::CNT_W) ? SLICE_W : vsrle_pkg::CNT_W;
  localparam logic [vsrle_pkg::CFG_W-1:0] DIM_CAP_C = vsrle_pkg::CFG_W'(DIM_CAP);

  localparam int AW = vsrle_pkg::ADDR_W;
  localparam int CW = vsrle_pkg::CNT_W;
  localparam int WW = vsrle_pkg::WORD_W;

  // ---------------------------------------------------------------------------
  // Configuration. Dimensions are stored already clamped to 1..cap, and the slice
  // size is multiplied out at write time so that the decode path sees a ready
  // product in the cycle right after the write.
  // ---------------------------------------------------------------------------
  logic                         compressed_mode;
  logic [DIM_W-1:0]             size_x;
  logic [DIM_W-1:0]             size_y;
  logic [vsrle_pkg::CFG_W-1:0]  size_z;
  logic [SLICE_W-1:0]           slice_size;

  logic [vsrle_pkg::CFG_W-1:0]  dim_clamped;
  logic [DIM_W-1:0]             mul_a;
  logic [DIM_W-1:0]             mul_b;

  always_comb begin
    if (cfg_data == '0) begin
      dim_clamped = vsrle_pkg::CFG_W'(1);
    end else if (cfg_data > DIM_CAP_C) begin
      dim_clamped = DIM_CAP_C;
    end else begin
      dim_clamped = cfg_data;
    end
    mul_a = (cfg_index == vsrle_pkg::REG_SIZE_X) ? dim_clamped[DIM_W-1:0] : size_x;
    mul_b = (cfg_index == vsrle_pkg::REG_SIZE_Y) ? dim_clamped[DIM_W-1:0] : size_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_mode <= 1'b0;
      size_x          <= DIM_W'(1);
      size_y          <= DIM_W'(1);
      size_z          <= vsrle_pkg::CFG_W'(1);
      slice_size      <= SLICE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        vsrle_pkg::REG_COMPRESSED_MODE: compressed_mode <= cfg_data[0];
        vsrle_pkg::REG_SIZE_X: begin
          size_x     <= dim_clamped[DIM_W-1:0];
          slice_size <= mul_a * mul_b;
        end
        vsrle_pkg::REG_SIZE_Y: begin
          size_y     <= dim_clamped[DIM_W-1:0];
          slice_size <= mul_a * mul_b;
        end
        vsrle_pkg::REG_SIZE_Z: size_z <= dim_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder state.
  // ---------------------------------------------------------------------------
  vsrle_pkg::phase_t            phase, phase_next;
  logic [CW-1:0]                pending, pending_next;
  logic [CW-1:0]                slice_index, slice_index_next;
  logic [vsrle_pkg::CFG_W-1:0]  slice_number, slice_number_next;
  logic [AW-1:0]                slice_base, slice_base_next;
  logic                         finished, finished_next;

  // Handshakes. A new word is taken whenever the output register is empty or is
  // being emptied in the same cycle.
  logic in_acc;
  assign words.ready = !runs.valid || runs.ready;
  assign in_acc      = words.valid && words.ready;

  // Precomputed candidates for closing one or two slices within a single word.
  logic [AW-1:0]                addr_cur, base_p1, base_p2;
  logic [vsrle_pkg::CFG_W-1:0]  num_p1, num_p2;
  logic                         fin_p1, fin_p2;
  logic [RW-1:0]                ss_r, idx_r, room;
  logic                         full;
  logic [CW-1:0]                idx_plain, idx_plain_inc;
  logic                         full_after;
  logic                         run_clip;
  logic [CW-1:0]                run_len;
  logic [WW-1:0]                w;

  // Result being formed for the output register.
  logic                         emit;
  logic [AW-1:0]                e_addr;
  logic [CW-1:0]                e_len;
  logic [WW-1:0]                e_val;
  logic                         e_ovf;
  logic                         e_done;

  always_comb begin
    w        = words.data_word;
    addr_cur = slice_base + AW'(slice_index);
    base_p1  = slice_base + AW'(slice_size);
    base_p2  = slice_base + AW'({slice_size, 1'b0});
    num_p1   = slice_number + vsrle_pkg::CFG_W'(1);
    num_p2   = slice_number + vsrle_pkg::CFG_W'(2);
    fin_p1   = num_p1 >= size_z;
    fin_p2   = num_p2 >= size_z;

    ss_r  = RW'(slice_size);
    idx_r = RW'(slice_index);
    full  = idx_r >= ss_r;
    room  = full ? '0 : (ss_r - idx_r);

    // Plain mode: a full slice is closed first, then the voxel is placed.
    idx_plain     = full ? '0 : slice_index;
    idx_plain_inc = idx_plain + CW'(1);
    full_after    = RW'(idx_plain_inc) >= ss_r;

    // Compressed run: the length is clipped to the room left in the slice.
    run_clip = RW'(pending) > room;
    run_len  = run_clip ? room[CW-1:0] : pending;
  end

  always_comb begin
    phase_next        = phase;
    pending_next      = pending;
    slice_index_next  = slice_index;
    slice_number_next = slice_number;
    slice_base_next   = slice_base;
    finished_next     = finished;
    emit              = 1'b0;
    e_addr            = addr_cur;
    e_len             = CW'(1);
    e_val             = w;
    e_ovf             = 1'b0;
    e_done            = 1'b0;

    if (in_acc && !finished) begin
      if (!compressed_mode) begin
        phase_next = vsrle_pkg::PH_WORD;
        if (full && fin_p1) begin
          // The slice that was already full was the last one: nothing to write.
          slice_base_next   = base_p1;
          slice_index_next  = '0;
          slice_number_next = num_p1;
          finished_next     = 1'b1;
        end else begin
          emit   = 1'b1;
          e_addr = full ? base_p1 : addr_cur;
          if (full_after) begin
            slice_index_next  = '0;
            slice_base_next   = full ? base_p2 : base_p1;
            slice_number_next = full ? num_p2 : num_p1;
            finished_next     = full ? fin_p2 : fin_p1;
            e_done            = full ? fin_p2 : fin_p1;
          end else begin
            slice_index_next  = idx_plain_inc;
            slice_base_next   = full ? base_p1 : slice_base;
            slice_number_next = full ? num_p1 : slice_number;
          end
        end
      end else begin
        case (phase)
          vsrle_pkg::PH_COUNT: begin
            // Counts beyond the counter range saturate.
            pending_next = (|w[WW-1:CW]) ? '1 : w[CW-1:0];
            phase_next   = vsrle_pkg::PH_VALUE;
          end
          vsrle_pkg::PH_VALUE: begin
            phase_next   = vsrle_pkg::PH_WORD;
            pending_next = '0;
            if (run_len != '0) begin
              emit             = 1'b1;
              e_len            = run_len;
              e_ovf            = run_clip;
              slice_index_next = slice_index + run_len;
            end
          end
          default: begin
            phase_next = vsrle_pkg::PH_WORD;
            if (w == vsrle_pkg::CODE_NEXT_SLICE) begin
              slice_base_next   = base_p1;
              slice_index_next  = '0;
              slice_number_next = num_p1;
              finished_next     = fin_p1;
              // Only the end of the last slice produces a marker transaction.
              emit   = fin_p1;
              e_len  = '0;
              e_val  = '0;
              e_done = 1'b1;
            end else if (w == vsrle_pkg::CODE_RUN) begin
              phase_next = vsrle_pkg::PH_COUNT;
            end else if (!full) begin
              emit             = 1'b1;
              slice_index_next = slice_index + CW'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vsrle_pkg::PH_WORD;
      pending      <= '0;
      slice_index  <= '0;
      slice_number <= '0;
      slice_base   <= '0;
      finished     <= 1'b0;
    end else begin
      phase        <= phase_next;
      pending      <= pending_next;
      slice_index  <= slice_index_next;
      slice_number <= slice_number_next;
      slice_base   <= slice_base_next;
      finished     <= finished_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It loads whenever the accepted word produces a run or the end marker and
  // otherwise drains on the downstream handshake.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      runs.valid <= 1'b0;
    end else if (emit) begin
      runs.valid <= 1'b1;
    end else if (runs.ready) begin
      runs.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      runs.voxel_address <= e_addr;
      runs.run_length    <= e_len;
      runs.voxel_value   <= e_val;
      runs.overflow      <= e_ovf;
      runs.matrix_done   <= e_done;
    end
  end

`ifndef SYNTH
  // Once the matrix is complete, further words leave the position untouched.
  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    (in_acc && finished) |=> ($stable(slice_base) && $stable(slice_index)
                              && finished))
    else $error("decoder state moved after the matrix was finished");

  // A transaction that completes the matrix always leaves the decoder finished.
  a_done_finished: assert property (@(posedge clk) disable iff (rst)
    (runs.valid && runs.matrix_done) |-> finished)
    else $error("matrix_done shown while the decoder is not finished");

  // Only the end-of-matrix marker has a zero length.
  a_zero_len_marker: assert property (@(posedge clk) disable iff (rst)
    (runs.valid && (runs.run_length == '0)) |-> runs.matrix_done)
    else $error("zero-length run without matrix_done");

  // A run code can only be in progress before the matrix is complete.
  a_phase_not_finished: assert property (@(posedge clk) disable iff (rst)
    (phase != vsrle_pkg::PH_WORD) |-> !finished)
    else $error("run code pending after the matrix was finished");
`endif

endmodule
